// ===== rtl/wsd_pkg.sv =====
// wsd_pkg: shared types and codes for the websocket frame deframer
// no dependencies; imported by every rtl module and by the checker
package wsd_pkg;

  localparam int unsigned LEN_BITS_DEF = 32;

  typedef enum logic [2:0] {
    PH_HDR0 = 3'd0,
    PH_HDR1 = 3'd1,
    PH_EXT  = 3'd2,
    PH_KEY  = 3'd3,
    PH_PAY  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    V_IGNORE = 3'd0,
    V_TEXT   = 3'd1,
    V_PING   = 3'd2,
    V_PONG   = 3'd3,
    V_CLOSE  = 3'd4,
    V_ERROR  = 3'd5
  } verdict_e;

  typedef enum logic [2:0] {
    EV_TEXT       = 3'd0,
    EV_EMPTY_END  = 3'd1,
    EV_PING       = 3'd2,
    EV_EMPTY_PING = 3'd3,
    EV_PONG       = 3'd4,
    EV_CLOSE      = 3'd5,
    EV_ERROR      = 3'd6
  } event_e;

  typedef enum logic [2:0] {
    ERR_FRAG_CTRL    = 3'd0,
    ERR_STRAY_CONT   = 3'd1,
    ERR_DATA_IN_FRAG = 3'd2,
    ERR_BINARY       = 3'd3,
    ERR_BAD_OP       = 3'd4,
    ERR_TOO_LONG     = 3'd5
  } err_e;

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_BIN   = 4'h2;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  typedef struct packed {
    event_e     ev;
    logic [7:0] data;
    logic       last;
    err_e       kind;
  } wsd_res_t;

endpackage

// ===== rtl/wsd_parser.sv =====
// wsd_parser: per-byte header parse, frame decision and payload unmask
// depends on wsd_pkg; one byte is consumed per take_i
module wsd_parser #(
  parameter int unsigned LEN_BITS = wsd_pkg::LEN_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        rx_byte_i,
  output logic              res_vld_o,
  output wsd_pkg::wsd_res_t res_o
);
  import wsd_pkg::*;

  localparam logic [63:0] LenHiMask =
    (LEN_BITS >= 64) ? 64'd0 : ~((64'd1 << LEN_BITS) - 64'd1);

  phase_e      phase_q, phase_d;
  logic        fin_q, fin_d;
  logic [3:0]  op_q, op_d;
  logic        mask_q, mask_d;
  logic [63:0] len_q, len_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  idx_q, idx_d;
  logic        frag_q, frag_d;
  logic        stopped_q, stopped_d;
  verdict_e    verd_q, verd_d;
  err_e        kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      fin_q     <= 1'b0;
      op_q      <= '0;
      mask_q    <= 1'b0;
      len_q     <= '0;
      cnt_q     <= '0;
      key_q     <= '0;
      idx_q     <= '0;
      frag_q    <= 1'b0;
      stopped_q <= 1'b0;
      verd_q    <= V_IGNORE;
      kind_q    <= ERR_FRAG_CTRL;
    end else begin
      phase_q   <= phase_d;
      fin_q     <= fin_d;
      op_q      <= op_d;
      mask_q    <= mask_d;
      len_q     <= len_d;
      cnt_q     <= cnt_d;
      key_q     <= key_d;
      idx_q     <= idx_d;
      frag_q    <= frag_d;
      stopped_q <= stopped_d;
      verd_q    <= verd_d;
      kind_q    <= kind_d;
    end
  end

  logic [7:0] key_byte;
  logic [7:0] pay_byte;

  always_comb begin
    case (idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
    pay_byte = rx_byte_i ^ key_byte;
  end

  logic     hdr_done;
  logic     end_frame;
  logic     had_byte;
  verdict_e end_verd;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    op_d      = op_q;
    mask_d    = mask_q;
    len_d     = len_q;
    cnt_d     = cnt_q;
    key_d     = key_q;
    idx_d     = idx_q;
    frag_d    = frag_q;
    stopped_d = stopped_q;
    verd_d    = verd_q;
    kind_d    = kind_q;
    hdr_done  = 1'b0;
    end_frame = 1'b0;
    had_byte  = 1'b0;
    res_vld_o = 1'b0;
    res_o     = '{ev: EV_TEXT, data: 8'd0, last: 1'b0, kind: ERR_FRAG_CTRL};

    if (take_i && !stopped_q) begin
      case (phase_q)
        PH_HDR0: begin
          fin_d   = rx_byte_i[7];
          op_d    = rx_byte_i[3:0];
          phase_d = PH_HDR1;
        end
        PH_HDR1: begin
          mask_d = rx_byte_i[7];
          key_d  = '0;
          len_d  = {57'd0, rx_byte_i[6:0]};
          if (rx_byte_i[6:0] == LEN7_EXT16) begin
            len_d   = '0;
            cnt_d   = 3'd1;
            phase_d = PH_EXT;
          end else if (rx_byte_i[6:0] == LEN7_EXT64) begin
            len_d   = '0;
            cnt_d   = 3'd7;
            phase_d = PH_EXT;
          end else if (rx_byte_i[7]) begin
            cnt_d   = 3'd3;
            phase_d = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
        PH_EXT: begin
          len_d = {len_q[55:0], rx_byte_i};
          if (cnt_q == 3'd0) begin
            if (mask_q) begin
              cnt_d   = 3'd3;
              phase_d = PH_KEY;
            end else begin
              hdr_done = 1'b1;
            end
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PH_KEY: begin
          key_d = {key_q[23:0], rx_byte_i};
          if (cnt_q == 3'd0) begin
            hdr_done = 1'b1;
          end else begin
            cnt_d = cnt_q - 3'd1;
          end
        end
        PH_PAY: begin
          idx_d = idx_q + 2'd1;
          len_d = len_q - 64'd1;
          if (len_q == 64'd1) begin
            end_frame = 1'b1;
            had_byte  = 1'b1;
          end else if (verd_q == V_TEXT) begin
            res_vld_o = 1'b1;
            res_o     = '{ev: EV_TEXT, data: pay_byte, last: 1'b0, kind: ERR_FRAG_CTRL};
          end else if (verd_q == V_PING) begin
            res_vld_o = 1'b1;
            res_o     = '{ev: EV_PING, data: pay_byte, last: 1'b0, kind: ERR_FRAG_CTRL};
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase
    end

    // frame decision on the last header byte
    if (hdr_done) begin
      kind_d = ERR_FRAG_CTRL;
      idx_d  = '0;
      if ((len_d & LenHiMask) != 64'd0) begin
        verd_d = V_ERROR;
        kind_d = ERR_TOO_LONG;
      end else if (op_q == OP_CLOSE) begin
        verd_d = V_CLOSE;
      end else if (op_q[3]) begin
        if (!fin_q) begin
          verd_d = V_ERROR;
          kind_d = ERR_FRAG_CTRL;
        end else if (op_q == OP_PING) begin
          verd_d = V_PING;
        end else if (op_q == OP_PONG) begin
          verd_d = V_PONG;
        end else begin
          verd_d = V_IGNORE;
        end
      end else if (op_q == OP_CONT) begin
        if (!frag_q) begin
          verd_d = V_ERROR;
          kind_d = ERR_STRAY_CONT;
        end else begin
          verd_d = V_TEXT;
          if (fin_q) frag_d = 1'b0;
        end
      end else if (frag_q) begin
        verd_d = V_ERROR;
        kind_d = ERR_DATA_IN_FRAG;
      end else if (op_q == OP_TEXT) begin
        verd_d = V_TEXT;
        if (!fin_q) frag_d = 1'b1;
      end else if (op_q == OP_BIN) begin
        verd_d = V_ERROR;
        kind_d = ERR_BINARY;
      end else begin
        verd_d = V_ERROR;
        kind_d = ERR_BAD_OP;
      end
      if (len_d == 64'd0) begin
        end_frame = 1'b1;
      end else begin
        phase_d = PH_PAY;
      end
    end

    end_verd = hdr_done ? verd_d : verd_q;

    if (end_frame) begin
      phase_d = PH_HDR0;
      case (end_verd)
        V_TEXT: begin
          if (had_byte) begin
            res_vld_o = 1'b1;
            res_o     = '{ev: EV_TEXT, data: pay_byte, last: fin_q, kind: ERR_FRAG_CTRL};
          end else if (fin_q) begin
            res_vld_o = 1'b1;
            res_o     = '{ev: EV_EMPTY_END, data: 8'd0, last: 1'b1, kind: ERR_FRAG_CTRL};
          end
        end
        V_PING: begin
          res_vld_o = 1'b1;
          if (had_byte) begin
            res_o = '{ev: EV_PING, data: pay_byte, last: 1'b1, kind: ERR_FRAG_CTRL};
          end else begin
            res_o = '{ev: EV_EMPTY_PING, data: 8'd0, last: 1'b1, kind: ERR_FRAG_CTRL};
          end
        end
        V_PONG: begin
          res_vld_o = 1'b1;
          res_o     = '{ev: EV_PONG, data: 8'd0, last: 1'b0, kind: ERR_FRAG_CTRL};
        end
        V_CLOSE: begin
          stopped_d = 1'b1;
          res_vld_o = 1'b1;
          res_o     = '{ev: EV_CLOSE, data: 8'd0, last: 1'b0, kind: ERR_FRAG_CTRL};
        end
        V_ERROR: begin
          stopped_d = 1'b1;
          res_vld_o = 1'b1;
          res_o     = '{ev: EV_ERROR, data: 8'd0, last: 1'b0, kind: kind_d};
        end
        default: begin
          res_vld_o = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== rtl/wsd_out_buf.sv =====
// wsd_out_buf: output register with one skid entry for result items
// depends on wsd_pkg; stall toward the parser comes from the skid entry only
module wsd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wsd_pkg::wsd_res_t res_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output wsd_pkg::wsd_res_t out_o
);
  import wsd_pkg::*;

  logic     out_vld_q, out_vld_d;
  logic     skid_vld_q, skid_vld_d;
  wsd_res_t out_q, out_d;
  wsd_res_t skid_q, skid_d;
  logic     pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  always_comb begin
    pop        = out_vld_q && !out_stall_i;
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_d     = res_i;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res_i;
        skid_vld_d = 1'b1;
      end
    end else if (pop) begin
      out_vld_d = 1'b0;
    end
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/websocket_frame_deframer.sv =====
// websocket_frame_deframer: top level of the receive frame parser
// depends on wsd_pkg, wsd_parser and wsd_out_buf
//
// usage
//   input channel: one received byte per item on rx_byte_i, taken when
//   in_valid_i is high and in_stall_o is low
//   output channel: zero or one result per input byte on event_res_o,
//   data_byte_o, last_o and error_kind_o, taken when out_valid_o is high
//   and out_stall_i is low
//   output path: a result is registered in the output register or skid entry
//   throughput: one byte per cycle while in_stall_o is low; the parser
//   state registers (phase, length counter, mask key) update on each byte
//   stall: results wait in an output register with one skid entry behind
//   it; in_stall_o rises only while the skid entry is occupied and drops
//   the cycle after the receiver takes the waiting result
//   reset: rst_ni low clears the parser to await a frame's first header
//   byte, clears the fragment and stop flags and empties both result
//   entries; after a close or an error all bytes are taken and dropped
//   until the next reset
module websocket_frame_deframer #(
  parameter int unsigned LEN_BITS = wsd_pkg::LEN_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] event_res_o,
  output logic [7:0] data_byte_o,
  output logic       last_o,
  output logic [2:0] error_kind_o
);
  import wsd_pkg::*;

  logic     take;
  logic     res_vld;
  wsd_res_t res;
  wsd_res_t out_res;
  logic     full;

  assign take       = in_valid_i && !full;
  assign in_stall_o = full;

  wsd_parser #(
    .LEN_BITS(LEN_BITS)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .rx_byte_i (rx_byte_i),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  wsd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && res_vld),
    .res_i       (res),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign event_res_o  = out_res.ev;
  assign data_byte_o  = out_res.data;
  assign last_o       = out_res.last;
  assign error_kind_o = out_res.kind;

endmodule

// ===== rtl/wsd_checker.sv =====
// wsd_checker: port-level assertions for websocket_frame_deframer
// depends on wsd_pkg; attached to the top level by the bind below
module wsd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] event_res_o,
  input logic [7:0] data_byte_o,
  input logic       last_o,
  input logic [2:0] error_kind_o
);
  import wsd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_res_o)
      && $stable(data_byte_o) && $stable(last_o) && $stable(error_kind_o))
    else $error("stalled result changed");

  // error kind only on error events
  a_kind_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_ERROR |-> error_kind_o == ERR_FRAG_CTRL)
    else $error("error kind on non-error event");

  // payload byte only on text and ping byte events
  a_data_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EV_TEXT && event_res_o != EV_PING
      |-> data_byte_o == 8'd0)
    else $error("data on non-data event");

  // empty events carry last, control reports do not
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((event_res_o == EV_EMPTY_END || event_res_o == EV_EMPTY_PING)
      ? last_o : ((event_res_o == EV_TEXT || event_res_o == EV_PING) || !last_o)))
    else $error("bad last flag");

  // input is taken again once the waiting result leaves
  a_stall_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o && !out_stall_i |=> !in_stall_o)
    else $error("stall held after result taken");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .event_res_o  (event_res_o),
  .data_byte_o  (data_byte_o),
  .last_o       (last_o),
  .error_kind_o (error_kind_o)
);
